>>> rtl/core/kit_pkg.sv
// ----------------------------------------------------------------------------
// kit_pkg
// Types and codes shared by the keyed item table: entry layout, operation
// and status codes, and the result word handed from sequencer to output.
// ----------------------------------------------------------------------------
`default_nettype none

package kit_pkg;

    localparam int NAME_BYTES = 29;
    localparam int KIND_BYTES = 19;
    localparam int NAME_W     = NAME_BYTES * 8;
    localparam int KIND_W     = KIND_BYTES * 8;
    localparam int AMT_W      = 31;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 3;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_NAME  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY_KIND  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_QTY     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TABLE_EMPTY = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd7;

    // where the entry fields of a result word come from
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_MEM  = 2'd1;
    localparam logic [1:0] SRC_KEY  = 2'd2;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [KIND_W-1:0] kind;
        logic [AMT_W-1:0]  amount;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [1:0]          src;
        logic [POS_W-1:0]    pos;
        logic [POS_W-1:0]    count;
        logic                last;
    } res_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/keyed_item_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_item_table_unit
// Fixed-capacity keyed table of named entries: add, remove, search, list.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_ready  | op, name, type tag, amount
//   out     | output    | out_valid / out_ready| status, entry, position, count
//
// Result word registered after acceptance: add scans for the name, then
// checks and appends; remove and search scan, then reply; a rejection that
// needs no scan replies without one. List: one word per cycle while the
// output is not stalled. Remove then moves each later entry down before
// returning to idle. Reset clears the entry count, not the entries; no
// clearing pass. A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_item_table_unit #(
    parameter int CAPACITY = 10
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [1:0]   op,
    input  wire logic [63:0]  name_bytes_0_7,
    input  wire logic [63:0]  name_bytes_8_15,
    input  wire logic [63:0]  name_bytes_16_23,
    input  wire logic [39:0]  name_bytes_24_28,
    input  wire logic [63:0]  kind_bytes_0_7,
    input  wire logic [63:0]  kind_bytes_8_15,
    input  wire logic [23:0]  kind_bytes_16_18,
    input  wire logic signed [31:0] amount,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [2:0]        status,
    output logic [63:0]       entry_name_0_7,
    output logic [63:0]       entry_name_8_15,
    output logic [63:0]       entry_name_16_23,
    output logic [39:0]       entry_name_24_28,
    output logic [63:0]       entry_kind_0_7,
    output logic [63:0]       entry_kind_8_15,
    output logic [23:0]       entry_kind_16_18,
    output logic [30:0]       entry_amount,
    output logic [3:0]        entry_position,
    output logic [3:0]        entries_now,
    output logic              last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    kit_pkg::entry_t        key_in;
    kit_pkg::entry_t        key_held;
    kit_pkg::entry_t        rd_data;
    kit_pkg::entry_t        wr_data;
    kit_pkg::entry_t        out_entry;
    kit_pkg::res_ctl_t      res_ctl;
    logic                   rd_en;
    logic                   wr_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic                   res_valid;
    logic                   res_ready;

    kit_trim #(
        .NBYTES (kit_pkg::NAME_BYTES)
    ) u_trim_name (
        .din  ({name_bytes_24_28, name_bytes_16_23, name_bytes_8_15, name_bytes_0_7}),
        .dout (key_in.name)
    );

    kit_trim #(
        .NBYTES (kit_pkg::KIND_BYTES)
    ) u_trim_kind (
        .din  ({kind_bytes_16_18, kind_bytes_8_15, kind_bytes_0_7}),
        .dout (key_in.kind)
    );

    assign key_in.amount = amount[kit_pkg::AMT_W-1:0];

    kit_store #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    kit_seq #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .key       (key_in),
        .amount    (amount),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .key_held  (key_held),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_ctl   (res_ctl)
    );

    kit_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_ctl        (res_ctl),
        .mem_entry      (rd_data),
        .key_entry      (key_held),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .entry          (out_entry),
        .entry_position (entry_position),
        .entries_now    (entries_now),
        .last           (last)
    );

    assign entry_name_0_7   = out_entry.name[63:0];
    assign entry_name_8_15  = out_entry.name[127:64];
    assign entry_name_16_23 = out_entry.name[191:128];
    assign entry_name_24_28 = out_entry.name[231:192];
    assign entry_kind_0_7   = out_entry.kind[63:0];
    assign entry_kind_8_15  = out_entry.kind[127:64];
    assign entry_kind_16_18 = out_entry.kind[151:128];
    assign entry_amount     = out_entry.amount;

endmodule

`default_nettype wire

>>> rtl/core/kit_trim.sv
// ----------------------------------------------------------------------------
// kit_trim
// Zeroes every byte after the first zero byte of a padded text field.
// ----------------------------------------------------------------------------
`default_nettype none

module kit_trim #(
    parameter int NBYTES = 29
) (
    input  wire logic [NBYTES*8-1:0] din,
    output logic      [NBYTES*8-1:0] dout
);

    logic [NBYTES-1:0] nz;
    logic [NBYTES-1:0] keep;

    for (genvar i = 0; i < NBYTES; i++) begin : g_byte
        localparam logic [NBYTES-1:0] LOW = (NBYTES'(1) << i) - NBYTES'(1);
        assign nz[i]          = |din[8*i +: 8];
        assign keep[i]        = &(nz | ~LOW);
        assign dout[8*i +: 8] = keep[i] ? din[8*i +: 8] : 8'h00;
    end

endmodule

`default_nettype wire

>>> rtl/core/kit_store.sv
// ----------------------------------------------------------------------------
// kit_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kit_store #(
    parameter int DEPTH = 10,
    parameter int IDX_W = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output kit_pkg::entry_t           rd_data,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire kit_pkg::entry_t      wr_data
);

    kit_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/kit_seq.sv
// ----------------------------------------------------------------------------
// kit_seq
// Operation sequencer: scans the entry memory for a name, appends on add,
// shifts entries down on remove, walks the table on list.
// ----------------------------------------------------------------------------
`default_nettype none

module kit_seq #(
    parameter int CAPACITY = 10,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           op,
    input  wire kit_pkg::entry_t      key,
    input  wire logic [31:0]          amount,
    output logic                      rd_en,
    output logic      [IDX_W-1:0]     rd_addr,
    input  wire kit_pkg::entry_t      rd_data,
    output logic                      wr_en,
    output logic      [IDX_W-1:0]     wr_addr,
    output kit_pkg::entry_t           wr_data,
    output kit_pkg::entry_t           key_held,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output kit_pkg::res_ctl_t         res_ctl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_ADDCHK = 3'd2;
    localparam logic [2:0] S_HIT    = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_LIST   = 3'd5;
    localparam logic [2:0] S_REPLY  = 3'd6;

    logic [2:0]                      state_reg, state_next;
    logic [1:0]                      op_reg, op_next;
    kit_pkg::entry_t                 key_reg, key_next;
    logic                            amt_bad_reg, amt_bad_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [kit_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [1:0]                      src_reg, src_next;
    logic [IDX_W-1:0]                pos_reg, pos_next;

    logic                            name_match;
    logic                            idx_at_end;
    logic [IDX_W-1:0]                idx_inc;
    logic [IDX_W-1:0]                idx_inc2;
    logic                            accept;

    assign name_match = (rd_data.name == key_reg.name);
    assign idx_inc    = idx_reg + IDX_W'(1);
    assign idx_inc2   = idx_inc + IDX_W'(1);
    assign idx_at_end = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign accept     = in_valid && in_ready;
    assign key_held   = key_reg;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        amt_bad_next = amt_bad_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        src_next     = src_reg;
        pos_next     = pos_reg;
        in_ready     = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = rd_data;
        res_valid    = 1'b0;
        res_ctl      = '{status: kit_pkg::ST_OK, src: kit_pkg::SRC_MEM,
                         pos: kit_pkg::POS_W'(idx_reg),
                         count: kit_pkg::POS_W'(count_reg), last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    op_next      = op;
                    key_next     = key;
                    amt_bad_next = (amount == 32'd0) || amount[31];
                    idx_next     = '0;
                    src_next     = kit_pkg::SRC_NONE;
                    pos_next     = '0;
                    unique case (op)
                        kit_pkg::OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = kit_pkg::ST_FULL;
                                state_next  = S_REPLY;
                            end
                            else if (key.name[7:0] == 8'h00)
                            begin
                                status_next = kit_pkg::ST_EMPTY_NAME;
                                state_next  = S_REPLY;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = S_ADDCHK;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        kit_pkg::OP_REMOVE, kit_pkg::OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = kit_pkg::ST_TABLE_EMPTY;
                                state_next  = S_REPLY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        kit_pkg::OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = kit_pkg::ST_TABLE_EMPTY;
                                state_next  = S_REPLY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // rd_data holds entry idx_reg; no new read on a match
            S_SCAN:
            begin
                if (name_match)
                begin
                    if (op_reg == kit_pkg::OP_ADD)
                    begin
                        status_next = kit_pkg::ST_DUPLICATE;
                        state_next  = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_HIT;
                    end
                end
                else if (idx_at_end)
                begin
                    if (op_reg == kit_pkg::OP_ADD)
                    begin
                        state_next = S_ADDCHK;
                    end
                    else
                    begin
                        status_next = kit_pkg::ST_NOT_FOUND;
                        state_next  = S_REPLY;
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc;
                    idx_next = idx_inc;
                end
            end

            S_ADDCHK:
            begin
                state_next = S_REPLY;
                if (key_reg.kind[7:0] == 8'h00)
                begin
                    status_next = kit_pkg::ST_EMPTY_KIND;
                end
                else if (amt_bad_reg)
                begin
                    status_next = kit_pkg::ST_BAD_QTY;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = count_reg[IDX_W-1:0];
                    wr_data     = key_reg;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = kit_pkg::ST_OK;
                    src_next    = kit_pkg::SRC_KEY;
                    pos_next    = count_reg[IDX_W-1:0];
                end
            end

            S_REPLY:
            begin
                res_valid = 1'b1;
                res_ctl   = '{status: status_reg, src: src_reg,
                              pos: kit_pkg::POS_W'(pos_reg),
                              count: kit_pkg::POS_W'(count_reg), last: 1'b1};
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            S_HIT:
            begin
                res_valid = 1'b1;
                if (op_reg == kit_pkg::OP_REMOVE)
                begin
                    res_ctl.count = kit_pkg::POS_W'(count_reg - CNT_W'(1));
                end
                if (res_ready)
                begin
                    if (op_reg != kit_pkg::OP_REMOVE)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        if (idx_at_end)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = idx_inc;
                            state_next = S_SHIFT;
                        end
                    end
                end
            end

            // rd_data holds entry idx_reg + 1 of the old layout
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (idx_at_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc2;
                    idx_next = idx_inc;
                end
            end

            S_LIST:
            begin
                res_valid    = 1'b1;
                res_ctl.last = idx_at_end;
                if (res_ready)
                begin
                    if (idx_at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc;
                        idx_next = idx_inc;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        amt_bad_reg <= amt_bad_next;
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        src_reg     <= src_next;
        pos_reg     <= pos_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en && (rd_addr == wr_addr)))
        else $error("read and write of the same entry in one cycle");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADDCHK) && wr_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not grow the table");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted word not taken up");

    a_shift_from_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (op_reg == kit_pkg::OP_REMOVE) && wr_en)
        else $error("shift outside a remove");
`endif

endmodule

`default_nettype wire

>>> rtl/core/kit_out.sv
// ----------------------------------------------------------------------------
// kit_out
// Output register: holds one result word, selects its entry fields from
// the memory read data, the held key or zero.
// ----------------------------------------------------------------------------
`default_nettype none

module kit_out (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               res_valid,
    output logic                                    res_ready,
    input  wire kit_pkg::res_ctl_t                  res_ctl,
    input  wire kit_pkg::entry_t                    mem_entry,
    input  wire kit_pkg::entry_t                    key_entry,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [kit_pkg::STATUS_W-1:0]       status,
    output kit_pkg::entry_t                         entry,
    output logic      [kit_pkg::POS_W-1:0]          entry_position,
    output logic      [kit_pkg::POS_W-1:0]          entries_now,
    output logic                                    last
);

    logic                   valid_reg;
    logic                   push;
    kit_pkg::entry_t        entry_sel;

    assign res_ready = !valid_reg || out_ready;
    assign push      = res_valid && res_ready;
    assign out_valid = valid_reg;

    always_comb
    begin
        case (res_ctl.src)
            kit_pkg::SRC_MEM: entry_sel = mem_entry;
            kit_pkg::SRC_KEY: entry_sel = key_entry;
            default:          entry_sel = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            status         <= res_ctl.status;
            entry          <= entry_sel;
            entry_position <= (res_ctl.src == kit_pkg::SRC_NONE) ? '0 : res_ctl.pos;
            entries_now    <= res_ctl.count;
            last           <= res_ctl.last;
        end
    end

endmodule

`default_nettype wire
